FILE: hdl/lzssd_pkg.sv
// Shared types and constants for the LZSS bit-stream decompressor.
`timescale 1ns / 1ps

package lzssd_pkg;

  // Widest offset field a command can carry, and the match length bias.
  localparam int OFF_MAX_W = 16;
  localparam int MIN_MATCH = 3;

  // Command codes passed from the parser to the copy engine.
  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [OFF_MAX_W-1:0] offset;  // match source offset
    logic [7:0]           arg;     // literal byte, or raw match length
  } cmd_t;

endpackage

FILE: hdl/lzssd_if.sv
// Valid/ready channel interfaces for compressed input and decoded results.
`timescale 1ns / 1ps

interface lzssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzssd_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_kind, output out_byte, output run_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input run_last,
                  output ready);
endinterface

FILE: hdl/lzssd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lzssd_front.sv
// Bit parser: splits compressed bytes into literal, match and end commands.
`timescale 1ns / 1ps

module lzssd_front #(
  parameter int OFFSET_BITS = 13,
  parameter int LENGTH_BITS = 4
) (
  input  logic            clk,
  input  logic            rst,
  lzssd_in_if.sink        stream,
  output logic            push_valid,
  input  logic            push_ready,
  output lzssd_pkg::cmd_t push_cmd
);
  import lzssd_pkg::*;

  localparam int FW = (OFFSET_BITS > 8) ? OFFSET_BITS : 8;
  localparam int RW = $clog2(FW + 1);

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;
  localparam logic [1:0] PH_LEN  = 2'd3;

  logic                   busy;
  logic [7:0]             shreg;
  logic [2:0]             bit_idx;
  logic [1:0]             phase;
  logic [FW-1:0]          field;
  logic [RW-1:0]          rem;
  logic [OFFSET_BITS-1:0] saved;

  logic          bit_in;
  logic [FW-1:0] shifted;
  logic          field_done;
  logic          is_end;
  logic          step;

  assign bit_in     = shreg[7];
  assign shifted    = {field[FW-2:0], bit_in};
  assign field_done = (phase != PH_FLAG) && (rem == RW'(1));
  assign stream.ready = !busy;

  always_comb begin
    push_valid      = 1'b0;
    push_cmd.op     = OP_LIT;
    push_cmd.offset = '0;
    push_cmd.arg    = '0;
    is_end          = 1'b0;
    if (busy && field_done) begin
      unique case (phase)
        PH_LIT: begin
          push_valid   = 1'b1;
          push_cmd.arg = shifted[7:0];
        end
        PH_OFF: begin
          if (shifted[OFFSET_BITS-1:0] == '0) begin
            push_valid  = 1'b1;
            push_cmd.op = OP_END;
            is_end      = 1'b1;
          end
        end
        PH_LEN: begin
          push_valid      = 1'b1;
          push_cmd.op     = OP_MATCH;
          push_cmd.offset = OFF_MAX_W'(saved);
          push_cmd.arg    = 8'(shifted[LENGTH_BITS-1:0]);
        end
        default: ;
      endcase
    end
  end

  // a bit is held back only while its command cannot enter the queue
  assign step = busy && !(push_valid && !push_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_FLAG;
      rem   <= '0;
    end else if (stream.valid && stream.ready) begin
      shreg   <= stream.in_byte;
      bit_idx <= 3'd7;
      busy    <= 1'b1;
    end else if (step) begin
      shreg   <= {shreg[6:0], 1'b0};
      bit_idx <= bit_idx - 3'd1;
      // end token drops the rest of the byte
      if (bit_idx == 3'd0 || is_end) begin
        busy <= 1'b0;
      end
      if (phase == PH_FLAG) begin
        field <= '0;
        phase <= bit_in ? PH_LIT : PH_OFF;
        rem   <= bit_in ? RW'(8) : RW'(OFFSET_BITS);
      end else if (!field_done) begin
        field <= shifted;
        rem   <= rem - RW'(1);
      end else if (phase == PH_OFF && !is_end) begin
        saved <= shifted[OFFSET_BITS-1:0];
        phase <= PH_LEN;
        field <= '0;
        rem   <= RW'(LENGTH_BITS);
      end else begin
        phase <= PH_FLAG;
      end
    end
  end

endmodule

FILE: hdl/lzssd_cmd_queue.sv
// Small FIFO of parsed commands between the parser and the copy engine.
`timescale 1ns / 1ps

module lzssd_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lzssd_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lzssd_pkg::cmd_t pop_cmd
);
  import lzssd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/lzssd_back.sv
// Copy engine: executes commands against the ring dictionary, drives results.
`timescale 1ns / 1ps

module lzssd_back #(
  parameter int OFFSET_BITS = 13,
  parameter int LENGTH_BITS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  lzssd_pkg::cmd_t cmd,
  lzssd_out_if.source     result
);
  import lzssd_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int CW = LENGTH_BITS + 1;

  // dictionary control
  logic [OB-1:0] head;
  logic [OB:0]   hwm;        // addresses 1 .. hwm-1 have been written
  logic          full;       // address 0 has been written
  // copy loop
  logic [OB-1:0] src;
  logic [CW-1:0] cnt;        // reads still to issue
  logic          pend;       // read data waiting to be emitted
  logic          pend_last;
  logic          pend_fwd;
  logic          pend_zero;
  logic [7:0]    fwd_data;
  // output register
  logic          out_valid;
  logic          out_kind;
  logic [7:0]    out_byte;
  logic          out_last;

  logic          out_free;
  logic          emit_copy;
  logic          issue;
  logic          pop;
  logic          pop_emit;
  logic [7:0]    copy_byte;
  logic [7:0]    rdata;
  logic          we;
  logic [7:0]    wdata;
  logic          src_written;

  assign out_free  = !out_valid || result.ready;
  assign emit_copy = pend && out_free;
  assign issue     = (cnt != '0) && (!pend || emit_copy);
  assign pop       = (cnt == '0) && !pend && cmd_valid && out_free;
  assign cmd_ready = pop;
  // a match command only loads the copy loop; its bytes come from emit_copy
  assign pop_emit  = pop && (cmd.op != OP_MATCH);

  assign copy_byte = pend_fwd ? fwd_data : (pend_zero ? 8'd0 : rdata);
  assign we        = emit_copy || (pop && cmd.op == OP_LIT);
  assign wdata     = emit_copy ? copy_byte : cmd.arg;

  // never-written entries read as zero
  assign src_written = (src == '0) ? full : ({1'b0, src} < hwm);

  lzssd_ram #(
    .WIDTH (8),
    .DEPTH (1 << OFFSET_BITS)
  ) u_dict (
    .clk   (clk),
    .we    (we),
    .waddr (head),
    .wdata (wdata),
    .re    (issue),
    .raddr (src),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= OB'(1);
      hwm       <= (OB + 1)'(1);
      full      <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (we) begin
        head <= head + OB'(1);
        if (head == '0) begin
          full <= 1'b1;
        end else if (({1'b0, head} + (OB + 1)'(1)) > hwm) begin
          hwm <= {1'b0, head} + (OB + 1)'(1);
        end
      end

      if (issue) begin
        src  <= src + OB'(1);
        cnt  <= cnt - CW'(1);
        pend <= 1'b1;
      end else if (emit_copy) begin
        pend <= 1'b0;
      end

      if (pop) begin
        unique case (cmd.op)
          OP_END: begin
            head <= OB'(1);
          end
          OP_MATCH: begin
            src <= cmd.offset[OB-1:0];
            cnt <= CW'(cmd.arg[LENGTH_BITS-1:0]) + CW'(MIN_MATCH);
          end
          default: ;
        endcase
      end

      if (emit_copy || pop_emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last <= (cnt == CW'(1));
      // the byte written this cycle is not in the read data yet
      pend_fwd  <= emit_copy && (src == head);
      pend_zero <= !src_written;
      fwd_data  <= copy_byte;
    end
    if (emit_copy) begin
      out_kind <= 1'b0;
      out_byte <= copy_byte;
      out_last <= pend_last;
    end else if (pop_emit) begin
      out_kind <= (cmd.op == OP_END);
      out_byte <= (cmd.op == OP_LIT) ? cmd.arg : 8'd0;
      out_last <= 1'b1;
    end
  end

  assign result.valid    = out_valid;
  assign result.out_kind = out_kind;
  assign result.out_byte = out_byte;
  assign result.run_last = out_last;

endmodule

FILE: hdl/lzss_bitstream_decompressor.sv
// Top level of the LZSS bit-stream decompressor.
`timescale 1ns / 1ps

// Usage:
//   stream : compressed bytes, one request per byte, parsed MSB first.
//   result : decoded bytes (out_kind 0) and end-of-stream marks (out_kind 1);
//            run_last flags the final result caused by one input byte.
// Structure: a bit parser turns each byte into commands (literal, match,
//   end) and feeds a two-entry command queue; a copy engine drains the
//   queue against a 2^OFFSET_BITS byte ring dictionary held in a RAM.
// Throughput: the parser accepts a byte, then parses one bit per cycle while
//   the queue takes its commands; it accepts no new byte until the last one
//   is used up. The copy engine emits a literal or end mark directly and a
//   match of N bytes with one RAM read per byte (18 results at most).
// Path: a literal is registered in the command queue and the output register;
//   a match's first byte also passes the source register and the RAM read.
// Reset: no clearing pass; a fill count marks which entries were written,
//   the rest read as zero. stream.ready is high the first cycle after reset.
// Stalls: while result waits in its output register the engine stops, the
//   queue fills and the parser holds its bit and keeps stream.ready low.
// At most one token completes per input byte (every token is longer than 8
//   bits), so run_last marks the final result of each command.

module lzss_bitstream_decompressor #(
  parameter int OFFSET_BITS = 13,
  parameter int LENGTH_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  lzssd_in_if.sink    stream,
  lzssd_out_if.source result
);
  import lzssd_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  lzssd_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lzssd_cmd_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lzssd_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .result    (result)
  );

endmodule
